### hdl/ellipse_radial_clamp_assert.svh
// Assertion macros for the ellipse clamp.
`ifndef ELLIPSE_RADIAL_CLAMP_ASSERT_SVH
`define ELLIPSE_RADIAL_CLAMP_ASSERT_SVH

// Same-cycle implication.
`define ERC_ASSERT_NOW(label, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("ellipse clamp: assertion failed");

// Next-cycle implication.
`define ERC_ASSERT_NEXT(label, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("ellipse clamp: assertion failed");

`endif

### hdl/erc_pkg.sv
package erc_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int FRAC_BITS_DEF  = 4;
  localparam int RAD_BITS       = 10;
  localparam int QUEUE_DEPTH    = 2;
  localparam int ADDR_BITS      = 5;
  localparam int DATA_BITS      = 32;

  localparam int CENTER_X_RST = 250;
  localparam int CENTER_Y_RST = 300;
  localparam int RADIUS_X_RST = 80;
  localparam int RADIUS_Y_RST = 60;
  localparam int DOT_RAD_RST  = 20;

  localparam logic [2:0] REG_CENTER_X = 3'd0;
  localparam logic [2:0] REG_CENTER_Y = 3'd1;
  localparam logic [2:0] REG_RADIUS_X = 3'd2;
  localparam logic [2:0] REG_RADIUS_Y = 3'd3;
  localparam logic [2:0] REG_DOT_RAD  = 3'd4;

  typedef enum logic [1:0] {
    KIND_NORMAL,
    KIND_CENTER,
    KIND_DEGEN
  } erc_kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_SEARCH,
    ST_DONE
  } erc_state_t;

  // Multiply sequence, one product per step.
  typedef enum logic [3:0] {
    MS_AX2, MS_AY2, MS_RX2, MS_RY2, MS_DX2, MS_DY2,
    MS_Q0, MS_Q1, MS_OL0, MS_OL1, MS_ORR, MS_PP,
    MS_RX_HI, MS_RX_LO, MS_RY_HI, MS_RY_LO
  } erc_mstep_t;

  typedef struct packed {
    logic take;
    logic load;
  } erc_stat_t;

endpackage

### hdl/erc_fifo.sv
module erc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             rd,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);
  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_wr;
  logic             do_rd;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end
endmodule

### hdl/erc_front.sv
module erc_front #(
  parameter int COORD_BITS = erc_pkg::COORD_BITS_DEF
) (
  input  logic [COORD_BITS-1:0]         point_x,
  input  logic [COORD_BITS-1:0]         point_y,
  input  logic [COORD_BITS-1:0]         center_x,
  input  logic [COORD_BITS-1:0]         center_y,
  input  logic [erc_pkg::RAD_BITS-1:0]  outer_radius_x,
  input  logic [erc_pkg::RAD_BITS-1:0]  outer_radius_y,
  input  logic [erc_pkg::RAD_BITS-1:0]  dot_radius,
  output logic [4*COORD_BITS+3:0]       item
);
  import erc_pkg::*;

  logic                  negx;
  logic                  negy;
  logic [COORD_BITS-1:0] adx;
  logic [COORD_BITS-1:0] ady;
  erc_kind_t             kind;

  assign negx = point_x < center_x;
  assign negy = point_y < center_y;
  assign adx  = negx ? center_x - point_x : point_x - center_x;
  assign ady  = negy ? center_y - point_y : point_y - center_y;

  // center wins over a collapsed inner ellipse
  always_comb begin
    if (adx == '0 && ady == '0) begin
      kind = KIND_CENTER;
    end else if (outer_radius_x <= dot_radius || outer_radius_y <= dot_radius) begin
      kind = KIND_DEGEN;
    end else begin
      kind = KIND_NORMAL;
    end
  end

  assign item = {kind, negx, negy, adx, ady, point_x, point_y};
endmodule

### hdl/erc_back.sv
module erc_back #(
  parameter int COORD_BITS = erc_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = erc_pkg::FRAC_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic [4*COORD_BITS+3:0]                item,
  input  logic                                   q_empty,
  input  logic [COORD_BITS-1:0]                  center_x,
  input  logic [COORD_BITS-1:0]                  center_y,
  input  logic [erc_pkg::RAD_BITS-1:0]           outer_radius_x,
  input  logic [erc_pkg::RAD_BITS-1:0]           outer_radius_y,
  input  logic [erc_pkg::RAD_BITS-1:0]           dot_radius,
  input  logic                                   pop,
  output logic                                   empty,
  output logic signed [COORD_BITS+FRAC_BITS+1:0] dot_x,
  output logic signed [COORD_BITS+FRAC_BITS+1:0] dot_y,
  output logic                                   follows,
  output erc_pkg::erc_stat_t                     stat
);
  import erc_pkg::*;

  localparam int C  = COORD_BITS;
  localparam int R  = RAD_BITS;
  localparam int S  = FRAC_BITS + RAD_BITS + 2;
  localparam int SB = $clog2(S);
  localparam int MA = 2 * C;
  localparam int MB = (2 * R > C) ? 2 * R : C;
  localparam int PW = MA + MB;
  localparam int QW = PW + 1;
  localparam int RB = 2 * C + 4 * R;
  localparam int W  = QW + 2 * S + 3;
  localparam int OB = C + FRAC_BITS + 2;

  erc_state_t state, state_next;
  erc_mstep_t step;

  erc_kind_t       kind;
  logic            negx, negy;
  logic [C-1:0]    adx, ady, px, py;
  logic [R-1:0]    ax, ay;
  logic [2*R-1:0]  ax2, ay2, rx2, ry2;
  logic [4*R-1:0]  orr, pp;
  logic [MA-1:0]   dx2, dy2;
  logic [QW-1:0]   q, ol;
  logic [RB-1:0]   rxb, ryb;
  logic            in_ell, in_ell_now;

  logic [MA-1:0]   opa;
  logic [MB-1:0]   opb;
  logic [PW-1:0]   prod;

  logic [W-1:0]    sa, sbs, sqs, cand, r_cur, bs_half;
  logic [S-1:0]    n, n_new, rxv, ryv;
  logic [SB-1:0]   bitc;
  logic            phase, take_b;
  logic            out_valid;
  logic [OB-1:0]   bx, by, res_x, res_y;
  logic            res_f;

  assign ax = outer_radius_x - dot_radius;
  assign ay = outer_radius_y - dot_radius;

  // shared multiplier, operands picked by step
  always_comb begin
    opa = '0;
    opb = '0;
    case (step)
      MS_AX2:   begin opa = MA'(ax);   opb = MB'(ax); end
      MS_AY2:   begin opa = MA'(ay);   opb = MB'(ay); end
      MS_RX2:   begin opa = MA'(outer_radius_x); opb = MB'(outer_radius_x); end
      MS_RY2:   begin opa = MA'(outer_radius_y); opb = MB'(outer_radius_y); end
      MS_DX2:   begin opa = MA'(adx);  opb = MB'(adx); end
      MS_DY2:   begin opa = MA'(ady);  opb = MB'(ady); end
      MS_Q0:    begin opa = dx2;       opb = MB'(ay2); end
      MS_Q1:    begin opa = dy2;       opb = MB'(ax2); end
      MS_OL0:   begin opa = dx2;       opb = MB'(ry2); end
      MS_OL1:   begin opa = dy2;       opb = MB'(rx2); end
      MS_ORR:   begin opa = MA'(rx2);  opb = MB'(ry2); end
      MS_PP:    begin opa = MA'(ax2);  opb = MB'(ay2); end
      MS_RX_HI: begin opa = dx2;       opb = MB'(pp[4*R-1:2*R]); end
      MS_RX_LO: begin opa = dx2;       opb = MB'(pp[2*R-1:0]); end
      MS_RY_HI: begin opa = dy2;       opb = MB'(pp[4*R-1:2*R]); end
      MS_RY_LO: begin opa = dy2;       opb = MB'(pp[2*R-1:0]); end
      default:  begin opa = '0;        opb = '0; end
    endcase
  end

  assign prod       = PW'(opa) * PW'(opb);
  assign in_ell_now = (ol <= QW'(orr)) && (q < QW'(pp));

  // digit search: largest n with (2n-1)^2 q <= (2 num)^2, kept as adds
  assign r_cur   = W'(phase ? ryb : rxb) << (2 * FRAC_BITS + 2);
  assign cand    = sa + sbs + sqs;
  assign take_b  = cand <= r_cur;
  assign bs_half = W'($signed(sbs) >>> 1);
  assign n_new   = take_b ? (n | (S'(1) << bitc)) : n;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (!q_empty) begin
          state_next = (erc_kind_t'(item[4*C+3:4*C+2]) == KIND_NORMAL) ? ST_MUL : ST_DONE;
        end
      end
      ST_MUL: begin
        if (step == MS_RX_HI && in_ell_now) begin
          state_next = ST_DONE;
        end else if (step == MS_RY_LO) begin
          state_next = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (bitc == '0 && phase) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid || pop) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    stat.take = (state == ST_IDLE) && !q_empty;
    stat.load = (state == ST_DONE) && (!out_valid || pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (stat.take) begin
      kind   <= erc_kind_t'(item[4*C+3:4*C+2]);
      negx   <= item[4*C+1];
      negy   <= item[4*C];
      adx    <= item[4*C-1:3*C];
      ady    <= item[3*C-1:2*C];
      px     <= item[2*C-1:C];
      py     <= item[C-1:0];
      step   <= MS_AX2;
      in_ell <= 1'b0;
    end
    if (state == ST_MUL) begin
      step <= erc_mstep_t'(step + 1'b1);
      case (step)
        MS_AX2:   ax2 <= prod[2*R-1:0];
        MS_AY2:   ay2 <= prod[2*R-1:0];
        MS_RX2:   rx2 <= prod[2*R-1:0];
        MS_RY2:   ry2 <= prod[2*R-1:0];
        MS_DX2:   dx2 <= prod[MA-1:0];
        MS_DY2:   dy2 <= prod[MA-1:0];
        MS_Q0:    q   <= QW'(prod);
        MS_Q1:    q   <= q + QW'(prod);
        MS_OL0:   ol  <= QW'(prod);
        MS_OL1:   ol  <= ol + QW'(prod);
        MS_ORR:   orr <= prod[4*R-1:0];
        MS_PP:    pp  <= prod[4*R-1:0];
        MS_RX_HI: begin
          rxb    <= RB'(prod);
          in_ell <= in_ell_now;
        end
        MS_RX_LO: rxb <= (rxb << (2 * R)) + RB'(prod);
        MS_RY_HI: ryb <= RB'(prod);
        MS_RY_LO: ryb <= (ryb << (2 * R)) + RB'(prod);
        default:  ;
      endcase
    end
    if (state == ST_MUL && step == MS_RY_LO) begin
      sa    <= W'(q);
      sbs   <= -(W'(q) << (S + 1));
      sqs   <= W'(q) << (2 * S);
      n     <= '0;
      bitc  <= SB'(S - 1);
      phase <= 1'b0;
    end
    if (state == ST_SEARCH) begin
      if (bitc == '0) begin
        // restart for the y axis on the same q
        if (!phase) begin
          rxv <= n_new;
        end else begin
          ryv <= n_new;
        end
        sa    <= W'(q);
        sbs   <= -(W'(q) << (S + 1));
        sqs   <= W'(q) << (2 * S);
        n     <= '0;
        bitc  <= SB'(S - 1);
        phase <= 1'b1;
      end else begin
        if (take_b) begin
          sa  <= cand;
          sbs <= bs_half + sqs;
        end else begin
          sbs <= bs_half;
        end
        sqs  <= sqs >> 2;
        n    <= n_new;
        bitc <= bitc - 1'b1;
      end
    end
  end

  assign bx = OB'(center_x) << FRAC_BITS;
  assign by = OB'(center_y) << FRAC_BITS;

  always_comb begin
    case (kind)
      KIND_CENTER: begin
        res_x = bx;
        res_y = by;
        res_f = 1'b1;
      end
      KIND_DEGEN: begin
        res_x = bx;
        res_y = by;
        res_f = 1'b0;
      end
      KIND_NORMAL: begin
        if (in_ell) begin
          res_x = OB'(px) << FRAC_BITS;
          res_y = OB'(py) << FRAC_BITS;
          res_f = 1'b1;
        end else begin
          res_x = negx ? bx - OB'(rxv) : bx + OB'(rxv);
          res_y = negy ? by - OB'(ryv) : by + OB'(ryv);
          res_f = 1'b0;
        end
      end
      default: begin
        res_x = bx;
        res_y = by;
        res_f = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (stat.load) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stat.load) begin
      dot_x   <= $signed(res_x);
      dot_y   <= $signed(res_y);
      follows <= res_f;
    end
  end

  assign empty = !out_valid;
endmodule

### hdl/ellipse_radial_clamp.sv
// Channel  | Handshake           | Payload
// ---------+---------------------+--------------------------------------------
// input    | push / full         | point_x, point_y (whole pixels)
// result   | pop / empty         | dot_x, dot_y (1/16 pixel, signed), follows
// config   | psel/penable/pwrite | paddr, pwdata, prdata, pready (always 1)
//
// Back end: a point at the center or with a collapsed inner ellipse goes
//   straight to the result register; a point that is followed takes 13
//   multiplier steps; any other point takes 16 steps on the one shared
//   multiplier, then one bit per cycle of the root-and-divide search,
//   x then y.
// Reset: synchronous, active high; config registers return to defaults.
// Stalls: a 2-beat queue sits between classifier and back end, and the
//   result register holds a beat until popped while new beats queue up.
`include "ellipse_radial_clamp_assert.svh"

module ellipse_radial_clamp #(
  parameter int COORD_BITS = erc_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = erc_pkg::FRAC_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [erc_pkg::ADDR_BITS-1:0]          paddr,
  input  logic [erc_pkg::DATA_BITS-1:0]          pwdata,
  output logic [erc_pkg::DATA_BITS-1:0]          prdata,
  output logic                                   pready,
  input  logic                                   push,
  output logic                                   full,
  input  logic [COORD_BITS-1:0]                  point_x,
  input  logic [COORD_BITS-1:0]                  point_y,
  output logic                                   empty,
  input  logic                                   pop,
  output logic signed [COORD_BITS+FRAC_BITS+1:0] dot_x,
  output logic signed [COORD_BITS+FRAC_BITS+1:0] dot_y,
  output logic                                   follows
);
  import erc_pkg::*;

  localparam int IW = 4 * COORD_BITS + 4;

  // config registers
  logic [COORD_BITS-1:0] center_x;
  logic [COORD_BITS-1:0] center_y;
  logic [RAD_BITS-1:0]   outer_radius_x;
  logic [RAD_BITS-1:0]   outer_radius_y;
  logic [RAD_BITS-1:0]   dot_radius;
  logic                  cfg_wr;
  logic [2:0]            reg_sel;

  logic [IW-1:0] front_item;
  logic [IW-1:0] q_item;
  logic          q_empty;
  logic          q_pop;
  erc_stat_t     stat;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_sel = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x       <= COORD_BITS'(CENTER_X_RST);
      center_y       <= COORD_BITS'(CENTER_Y_RST);
      outer_radius_x <= RAD_BITS'(RADIUS_X_RST);
      outer_radius_y <= RAD_BITS'(RADIUS_Y_RST);
      dot_radius     <= RAD_BITS'(DOT_RAD_RST);
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_CENTER_X: center_x       <= pwdata[COORD_BITS-1:0];
        REG_CENTER_Y: center_y       <= pwdata[COORD_BITS-1:0];
        REG_RADIUS_X: outer_radius_x <= pwdata[RAD_BITS-1:0];
        REG_RADIUS_Y: outer_radius_y <= pwdata[RAD_BITS-1:0];
        REG_DOT_RAD:  dot_radius     <= pwdata[RAD_BITS-1:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_CENTER_X: prdata = DATA_BITS'(center_x);
      REG_CENTER_Y: prdata = DATA_BITS'(center_y);
      REG_RADIUS_X: prdata = DATA_BITS'(outer_radius_x);
      REG_RADIUS_Y: prdata = DATA_BITS'(outer_radius_y);
      REG_DOT_RAD:  prdata = DATA_BITS'(dot_radius);
      default:      prdata = '0;
    endcase
  end

  // front: offsets, signs and the special cases
  erc_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .point_x       (point_x),
    .point_y       (point_y),
    .center_x      (center_x),
    .center_y      (center_y),
    .outer_radius_x(outer_radius_x),
    .outer_radius_y(outer_radius_y),
    .dot_radius    (dot_radius),
    .item          (front_item)
  );

  // decoupling queue; full is the input backpressure
  erc_fifo #(
    .WIDTH(IW),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .wr   (push),
    .wdata(front_item),
    .full (full),
    .rd   (q_pop),
    .rdata(q_item),
    .empty(q_empty)
  );

  // back: multiply sequence, search, result register
  erc_back #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .item          (q_item),
    .q_empty       (q_empty),
    .center_x      (center_x),
    .center_y      (center_y),
    .outer_radius_x(outer_radius_x),
    .outer_radius_y(outer_radius_y),
    .dot_radius    (dot_radius),
    .pop           (pop),
    .empty         (empty),
    .dot_x         (dot_x),
    .dot_y         (dot_y),
    .follows       (follows),
    .stat          (stat)
  );

  assign q_pop = stat.take;

  // back end never pulls from an empty queue
  `ERC_ASSERT_NOW(a_take_nonempty, q_pop, !q_empty)
  // a beat written with no read leaves the queue non-empty
  `ERC_ASSERT_NEXT(a_queue_holds, push && !full && !q_pop, !q_empty)
  // a popped result with no refill drains the result register
  `ERC_ASSERT_NEXT(a_result_drains, pop && !empty && !stat.load, empty)
endmodule
